>>> hdl/sdv_pkg.sv
// Shared types and register codes for the sphere signed-distance voxel core.
package sdv_pkg;

  typedef struct packed {
    logic [7:0] x_index;
    logic [7:0] y_index;
    logic [7:0] z_index;
    logic       kind;
  } item_t;

  typedef struct packed {
    logic signed [31:0] distance_value;
    logic               saturated;
  } result_t;

  typedef enum logic [2:0] {
    REG_OFFSET_X       = 3'd0,
    REG_OFFSET_Y       = 3'd1,
    REG_OFFSET_Z       = 3'd2,
    REG_STEP_X         = 3'd3,
    REG_STEP_Y         = 3'd4,
    REG_STEP_Z         = 3'd5,
    REG_RADIUS         = 3'd6,
    REG_HALF_THICKNESS = 3'd7
  } reg_index_t;

  localparam int unsigned RootBits = 32;
  localparam int unsigned RadBits  = 2 * RootBits;
  localparam int unsigned RemBits  = RootBits + 3;

  // State handed from one square-root cell to the next.
  typedef struct packed {
    logic                 valid;
    logic                 kind;
    logic                 flag;
    logic [RadBits-1:0]   radicand;
    logic [RemBits-1:0]   rem;
    logic [RootBits-1:0]  root;
  } root_link_t;

endpackage

>>> hdl/sdv_axis.sv
// One axis: clipped position offset + step * index, then its square.
module sdv_axis (
  input  logic               clk,
  input  logic               en,
  input  logic signed [31:0] offset,
  input  logic [30:0]        step,
  input  logic [7:0]         index,
  output logic [63:0]        sq,
  output logic               clip
);
  import sdv_pkg::*;

  logic [38:0]        prod;
  logic signed [40:0] pos;
  logic signed [31:0] pos_clip;
  logic               pos_over;
  logic [31:0]        mag_comb;
  logic [31:0]        mag;
  logic               mag_clip;

  assign prod = 39'(step) * 39'(index);
  assign pos  = $signed({{9{offset[31]}}, offset}) + $signed({2'b00, prod});

  always_comb begin
    pos_over = 1'b1;
    if (pos > $signed(41'h000_7FFF_FFFF)) begin
      pos_clip = 32'sh7FFF_FFFF;
    end else if (pos < $signed(41'h1FF_8000_0000)) begin
      pos_clip = 32'sh8000_0000;
    end else begin
      pos_clip = pos[31:0];
      pos_over = 1'b0;
    end
  end

  // Most negative value maps to 2^31, which still fits 32 unsigned bits.
  assign mag_comb = pos_clip[31] ? (~pos_clip + 32'd1) : pos_clip;

  always_ff @(posedge clk) begin
    if (en) begin
      mag      <= mag_comb;
      mag_clip <= pos_over;
      sq       <= {32'd0, mag} * {32'd0, mag};
      clip     <= mag_clip;
    end
  end

endmodule

>>> hdl/sdv_root_cell.sv
// One restoring square-root cell: settles one root bit per cycle while en is high.
module sdv_root_cell (
  input  logic                clk,
  input  logic                rst,
  input  logic                en,
  input  sdv_pkg::root_link_t link_in,
  output sdv_pkg::root_link_t link_out
);
  import sdv_pkg::*;

  logic [RemBits-1:0] rem_sh;
  logic [RemBits-1:0] trial;
  logic               fits;

  assign rem_sh = {link_in.rem[RemBits-3:0], link_in.radicand[RadBits-1 -: 2]};
  assign trial  = {1'b0, link_in.root, 2'b01};
  assign fits   = rem_sh >= trial;

  always_ff @(posedge clk) begin
    if (rst) begin
      link_out.valid <= 1'b0;
    end else if (en) begin
      link_out.valid <= link_in.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      link_out.kind     <= link_in.kind;
      link_out.flag     <= link_in.flag;
      link_out.radicand <= {link_in.radicand[RadBits-3:0], 2'b00};
      link_out.rem      <= fits ? (rem_sh - trial) : rem_sh;
      link_out.root     <= {link_in.root[RootBits-2:0], fits};
    end
  end

endmodule

>>> hdl/sphere_signed_distance_voxel_core.sv
// Top level of the sphere signed-distance voxel core.
// Takes one voxel transaction per cycle unless item_stall is high and returns one signed
// Q16.16 distance per voxel, in order. The pipeline is the square-root chain: 32 cells,
// one root bit each, behind an input register (loaded at the accepting edge), two
// per-axis stages (clipped position, square) and one sum stage, followed by an output
// register. Ball kind gives distance minus radius; shell kind gives the absolute value
// of that minus half_thickness. saturated is set when an axis position or the final
// value was clipped to 32 signed bits. Write registers only while idle.
module sphere_signed_distance_voxel_core (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_write,
  input  logic [2:0]       cfg_index,
  input  logic [31:0]      cfg_data,
  input  logic             item_valid,
  output logic             item_stall,
  input  sdv_pkg::item_t   item,
  output logic             result_valid,
  input  logic             result_stall,
  output sdv_pkg::result_t result
);
  import sdv_pkg::*;

  // Configuration registers.
  logic signed [31:0] offset_x, offset_y, offset_z;
  logic [30:0]        step_x, step_y, step_z;
  logic [30:0]        radius, half_thickness;

  always_ff @(posedge clk) begin
    if (rst) begin
      offset_x       <= '0;
      offset_y       <= '0;
      offset_z       <= '0;
      step_x         <= 31'd65536;
      step_y         <= 31'd65536;
      step_z         <= 31'd65536;
      radius         <= 31'd65536;
      half_thickness <= '0;
    end else if (cfg_write) begin
      unique case (reg_index_t'(cfg_index))
        REG_OFFSET_X:       offset_x       <= cfg_data;
        REG_OFFSET_Y:       offset_y       <= cfg_data;
        REG_OFFSET_Z:       offset_z       <= cfg_data;
        REG_STEP_X:         step_x         <= cfg_data[30:0];
        REG_STEP_Y:         step_y         <= cfg_data[30:0];
        REG_STEP_Z:         step_z         <= cfg_data[30:0];
        REG_RADIUS:         radius         <= cfg_data[30:0];
        REG_HALF_THICKNESS: half_thickness <= cfg_data[30:0];
        default: ;
      endcase
    end
  end

  // Pipeline advance. The whole row moves together; it may also move while the
  // output holds a stalled result, as long as the last cell carries a bubble.
  root_link_t link [0:RootBits];
  logic       en;

  assign en         = !result_valid || !result_stall || !link[RootBits].valid;
  assign item_stall = !en;

  // Input register.
  item_t in_reg;
  logic  in_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (en) begin
      in_valid <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      in_reg <= item;
    end
  end

  // Per-axis position and square, two stages each.
  logic [63:0] sq_x, sq_y, sq_z;
  logic        clip_x, clip_y, clip_z;

  sdv_axis u_axis_x (
    .clk(clk), .en(en), .offset(offset_x), .step(step_x), .index(in_reg.x_index),
    .sq(sq_x), .clip(clip_x)
  );
  sdv_axis u_axis_y (
    .clk(clk), .en(en), .offset(offset_y), .step(step_y), .index(in_reg.y_index),
    .sq(sq_y), .clip(clip_y)
  );
  sdv_axis u_axis_z (
    .clk(clk), .en(en), .offset(offset_z), .step(step_z), .index(in_reg.z_index),
    .sq(sq_z), .clip(clip_z)
  );

  // Carry valid and kind alongside the two axis stages.
  logic [1:0] ax_valid;
  logic [1:0] ax_kind;

  always_ff @(posedge clk) begin
    if (rst) begin
      ax_valid <= '0;
    end else if (en) begin
      ax_valid <= {ax_valid[0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ax_kind <= {ax_kind[0], in_reg.kind};
    end
  end

  // Sum of squares; three squares of at most 2^62 each fit in 64 bits.
  logic [63:0] sum;
  logic        sum_valid, sum_kind, sum_flag;

  always_ff @(posedge clk) begin
    if (rst) begin
      sum_valid <= 1'b0;
    end else if (en) begin
      sum_valid <= ax_valid[1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sum      <= sq_x + sq_y + sq_z;
      sum_kind <= ax_kind[1];
      sum_flag <= clip_x | clip_y | clip_z;
    end
  end

  // Square-root chain: feed the sum in with an empty remainder and root.
  always_comb begin
    link[0].valid    = sum_valid;
    link[0].kind     = sum_kind;
    link[0].flag     = sum_flag;
    link[0].radicand = sum;
    link[0].rem      = '0;
    link[0].root     = '0;
  end

  for (genvar i = 0; i < RootBits; i++) begin : g_cell
    sdv_root_cell u_cell (
      .clk(clk), .rst(rst), .en(en), .link_in(link[i]), .link_out(link[i+1])
    );
  end

  // Final combine: distance minus radius, fold for the shell, clip.
  logic signed [35:0] diff;
  logic signed [35:0] folded;
  logic signed [35:0] fin;
  logic signed [31:0] fin_clip;
  logic               fin_over;

  assign diff   = $signed({4'b0, link[RootBits].root}) - $signed({5'b0, radius});
  assign folded = (link[RootBits].kind && diff[35]) ? -diff : diff;
  assign fin    = link[RootBits].kind ? (folded - $signed({5'b0, half_thickness}))
                                      : folded;

  always_comb begin
    fin_over = 1'b1;
    if (fin > $signed(36'h0_7FFF_FFFF)) begin
      fin_clip = 32'sh7FFF_FFFF;
    end else if (fin < $signed(36'hF_8000_0000)) begin
      fin_clip = 32'sh8000_0000;
    end else begin
      fin_clip = fin[31:0];
      fin_over = 1'b0;
    end
  end

  // Output register: load whenever it is empty or being taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (!result_valid || !result_stall) begin
      result_valid <= link[RootBits].valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!result_valid || !result_stall) begin
      result.distance_value <= fin_clip;
      result.saturated      <= fin_over | link[RootBits].flag;
    end
  end

  // An empty output register never holds back the input side.
  a_no_stall_when_empty : assert property (@(posedge clk) disable iff (rst)
    !result_valid |-> !item_stall)
    else $error("input stalled while output register is empty");

  // An accepted transaction lands in the input register.
  a_accept_loads : assert property (@(posedge clk) disable iff (rst)
    (item_valid && !item_stall) |=> in_valid)
    else $error("accepted transaction lost at input register");

  // A radius write takes effect on the next cycle.
  a_radius_write : assert property (@(posedge clk) disable iff (rst)
    (cfg_write && cfg_index == REG_RADIUS) |=> (radius == $past(cfg_data[30:0])))
    else $error("radius write not applied");

endmodule

>>> dv/tb_sphere_signed_distance_voxel_core.sv
// Self-checking testbench for the sphere signed-distance voxel core.
`timescale 1ns / 100ps

module tb_sphere_signed_distance_voxel_core;
  import sdv_pkg::*;

  // Pipeline depth, used to pad the final wait for late results.
  localparam int unsigned PipeDepth = 36;
  localparam int unsigned RandomPhases = 6;
  localparam int unsigned VoxelsPerPhase = 75;
  localparam longint S32Max = 64'sd2147483647;
  localparam longint S32Min = -64'sd2147483648;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic cfg_write = 1'b0;
  logic [2:0] cfg_index = '0;
  logic [31:0] cfg_data = '0;

  logic item_valid = 1'b0;
  logic item_stall;
  item_t item = '0;
  logic result_valid;
  logic result_stall = 1'b0;
  result_t result;

  // Shadow copy of the geometry registers, starting at their reset values.
  logic signed [31:0] cur_offset [3] = '{32'sd0, 32'sd0, 32'sd0};
  logic [30:0] cur_step [3] = '{31'd65536, 31'd65536, 31'd65536};
  logic [30:0] cur_radius = 31'd65536;
  logic [30:0] cur_half = 31'd0;

  item_t voxel_queue [$];     // voxels waiting to be driven
  result_t distance_due [$];  // predicted distances, oldest first

  int unsigned send_gap = 0;
  int unsigned stall_left = 0;
  bit no_idle = 1'b0;
  int unsigned mismatches = 0;

  sphere_signed_distance_voxel_core dut (
    .clk(clk),
    .rst(rst),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .item_valid(item_valid),
    .item_stall(item_stall),
    .item(item),
    .result_valid(result_valid),
    .result_stall(result_stall),
    .result(result)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Compute the signed distance of one voxel against the shadow registers.
  function automatic result_t sphere_distance(item_t vox);
    logic [7:0] idx [3];
    longint pos;
    longint diff;
    longint unsigned sum_sq;
    longint unsigned root;
    longint unsigned trial;
    bit clipped;
    result_t r;
    idx[0] = vox.x_index;
    idx[1] = vox.y_index;
    idx[2] = vox.z_index;
    clipped = 1'b0;
    sum_sq = 0;
    for (int a = 0; a < 3; a++) begin
      // Form the axis position exactly, then clip it to 32 signed bits.
      pos = longint'(cur_offset[a]) + longint'(cur_step[a]) * longint'(idx[a]);
      if (pos > S32Max) begin
        pos = S32Max;
        clipped = 1'b1;
      end else if (pos < S32Min) begin
        pos = S32Min;
        clipped = 1'b1;
      end
      if (pos < 0) pos = -pos;
      sum_sq += longint'(pos * pos);
    end
    // Truncated square root, one bit at a time from the top.
    root = 0;
    for (int b = 31; b >= 0; b--) begin
      trial = root | (64'd1 << b);
      if (trial * trial <= sum_sq) root = trial;
    end
    diff = longint'(root) - longint'(cur_radius);
    if (vox.kind) begin
      if (diff < 0) diff = -diff;
      diff -= longint'(cur_half);
    end
    if (diff > S32Max) begin
      diff = S32Max;
      clipped = 1'b1;
    end else if (diff < S32Min) begin
      diff = S32Min;
      clipped = 1'b1;
    end
    r.distance_value = diff[31:0];
    r.saturated = clipped;
    return r;
  endfunction

  // Print one line per mismatch and count every one.
  task automatic report_mismatch(string what, longint got, longint want);
    $display("MISMATCH %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    mismatches++;
  endtask

  // Driver: queue the prediction for each accepted voxel, hold a stalled one,
  // otherwise idle in bursts or present the next pending voxel.
  always @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else begin
      if (item_valid && !item_stall)
        distance_due.push_back(sphere_distance(item));
      if (!(item_valid && item_stall)) begin
        if (send_gap > 0) begin
          send_gap--;
          item_valid <= 1'b0;
        end else if (!no_idle && $urandom_range(0, 9) == 0) begin
          send_gap = $urandom_range(1, 16) - 1;
          item_valid <= 1'b0;
        end else if (voxel_queue.size() != 0) begin
          item <= voxel_queue.pop_front();
          item_valid <= 1'b1;
        end else begin
          item_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: stall the result side in bursts and check each accepted result
  // against the oldest prediction.
  always @(posedge clk) begin
    result_t want;
    if (rst) begin
      result_stall <= 1'b0;
    end else begin
      if (result_valid && !result_stall) begin
        if (distance_due.size() == 0) begin
          report_mismatch("unexpected result", result.distance_value, 0);
        end else begin
          want = distance_due.pop_front();
          if (result.distance_value !== want.distance_value)
            report_mismatch("distance_value", result.distance_value, want.distance_value);
          if (result.saturated !== want.saturated)
            report_mismatch("saturated", result.saturated, want.saturated);
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        result_stall <= 1'b1;
      end else if (!no_idle && $urandom_range(0, 9) == 0) begin
        stall_left = $urandom_range(1, 16) - 1;
        result_stall <= 1'b1;
      end else begin
        result_stall <= 1'b0;
      end
    end
  end

  // Write one register at the next edge and mirror it in the shadow copy.
  task automatic write_reg(reg_index_t idx, logic [31:0] data);
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    case (idx)
      REG_OFFSET_X: cur_offset[0] = data;
      REG_OFFSET_Y: cur_offset[1] = data;
      REG_OFFSET_Z: cur_offset[2] = data;
      REG_STEP_X: cur_step[0] = data[30:0];
      REG_STEP_Y: cur_step[1] = data[30:0];
      REG_STEP_Z: cur_step[2] = data[30:0];
      REG_RADIUS: cur_radius = data[30:0];
      REG_HALF_THICKNESS: cur_half = data[30:0];
      default: ;
    endcase
  endtask

  task automatic load_geometry(logic [31:0] ox, logic [31:0] oy, logic [31:0] oz,
                               logic [31:0] sx, logic [31:0] sy, logic [31:0] sz,
                               logic [31:0] rad, logic [31:0] half);
    write_reg(REG_OFFSET_X, ox);
    write_reg(REG_OFFSET_Y, oy);
    write_reg(REG_OFFSET_Z, oz);
    write_reg(REG_STEP_X, sx);
    write_reg(REG_STEP_Y, sy);
    write_reg(REG_STEP_Z, sz);
    write_reg(REG_RADIUS, rad);
    write_reg(REG_HALF_THICKNESS, half);
    @(posedge clk);
    cfg_write <= 1'b0;
    @(negedge clk);
  endtask

  task automatic push_voxel(logic [7:0] x, logic [7:0] y, logic [7:0] z, logic k);
    item_t v;
    v.x_index = x;
    v.y_index = y;
    v.z_index = z;
    v.kind = k;
    voxel_queue.push_back(v);
  endtask

  // Hold until every pending voxel is accepted and every result has come back.
  // Sample at the falling edge so queue updates of the rising edge have settled.
  task automatic wait_idle();
    do @(negedge clk);
    while (voxel_queue.size() != 0 || item_valid || distance_due.size() != 0);
  endtask

  task automatic push_random(int unsigned count);
    repeat (count)
      push_voxel($urandom_range(0, 255), $urandom_range(0, 255), $urandom_range(0, 255),
                 $urandom_range(0, 1));
  endtask

  // Random geometry: mostly a sphere sitting inside the grid, sometimes raw bits.
  task automatic load_random_geometry(bit wild);
    longint stp [3];
    longint ofs [3];
    longint rad;
    longint half;
    if (wild) begin
      load_geometry($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                    $urandom, $urandom);
    end else begin
      for (int a = 0; a < 3; a++) begin
        stp[a] = $urandom_range(1, 1 << 18);
        ofs[a] = -stp[a] * $urandom_range(0, 255) + $urandom_range(0, 65535) - 32768;
      end
      rad = stp[0] * $urandom_range(0, 160);
      half = $urandom_range(0, 4 * int'(stp[1]));
      load_geometry(ofs[0][31:0], ofs[1][31:0], ofs[2][31:0], stp[0][31:0], stp[1][31:0],
                    stp[2][31:0], rad[31:0], half[31:0]);
    end
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Reset geometry: unit steps, unit radius, no shell thickness.
    push_voxel(8'd0, 8'd0, 8'd0, 1'b0);
    push_voxel(8'd0, 8'd0, 8'd0, 1'b1);
    push_voxel(8'd1, 8'd0, 8'd0, 1'b0);
    push_voxel(8'd3, 8'd4, 8'd0, 1'b0);
    push_voxel(8'd255, 8'd0, 8'd0, 1'b1);
    push_voxel(8'd255, 8'd255, 8'd255, 1'b0);
    push_voxel(8'd255, 8'd255, 8'd255, 1'b1);
    wait_idle();

    // Largest offsets and steps: clip the axis positions.
    load_geometry(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                  32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    push_voxel(8'd0, 8'd0, 8'd0, 1'b0);
    push_voxel(8'd1, 8'd0, 8'd0, 1'b1);
    push_voxel(8'd0, 8'd255, 8'd0, 1'b1);
    push_voxel(8'd255, 8'd255, 8'd255, 1'b0);
    push_voxel(8'd255, 8'd255, 8'd255, 1'b1);
    wait_idle();

    // Most negative offsets, zero steps and radius: the distance itself overflows.
    load_geometry(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'd0, 32'd0, 32'd0,
                  32'd0, 32'd0);
    push_voxel(8'd0, 8'd0, 8'd0, 1'b0);
    push_voxel(8'd200, 8'd17, 8'd99, 1'b1);
    wait_idle();

    // Tiny steps: the root truncates on sums that are not perfect squares.
    load_geometry(32'hFFFF_FF80, 32'd0, 32'd5, 32'd1, 32'd1, 32'd1, 32'd0, 32'd3);
    push_voxel(8'd129, 8'd1, 8'd0, 1'b0);
    push_voxel(8'd130, 8'd3, 8'd2, 1'b1);
    push_voxel(8'd128, 8'd0, 8'd0, 1'b1);
    push_voxel(8'd255, 8'd255, 8'd255, 1'b0);
    wait_idle();

    // Sphere of radius 100 centered in the grid, shell of half thickness 2.
    load_geometry(-32'sd8388608, -32'sd8388608, -32'sd8388608, 32'd65536, 32'd65536,
                  32'd65536, 32'd6553600, 32'd131072);
    push_voxel(8'd228, 8'd128, 8'd128, 1'b0);
    push_voxel(8'd228, 8'd128, 8'd128, 1'b1);
    push_voxel(8'd229, 8'd129, 8'd127, 1'b1);
    push_voxel(8'd128, 8'd128, 8'd128, 1'b1);
    wait_idle();

    // Random phases; the last one runs with no idling on either side.
    for (int p = 0; p < RandomPhases; p++) begin
      load_random_geometry(p % 3 == 2);
      if (p == RandomPhases - 1) no_idle = 1'b1;
      push_random(VoxelsPerPhase / 2);
      // Hold the sender off until the pipeline has drained, then resume.
      wait_idle();
      push_random(VoxelsPerPhase - VoxelsPerPhase / 2);
      wait_idle();
    end

    repeat (PipeDepth + 3) @(posedge clk);
    @(negedge clk);
    if (distance_due.size() != 0)
      report_mismatch("results missing", 0, distance_due.size());

    if (mismatches == 0) begin
      $display("tb_sphere_signed_distance_voxel_core OK");
    end else begin
      $display("tb_sphere_signed_distance_voxel_core NOT OK");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest correct run.
  initial begin
    #2000000;
    $display("tb_sphere_signed_distance_voxel_core NOT OK");
    $finish;
  end

endmodule

>>> files.f
hdl/sdv_pkg.sv
hdl/sdv_axis.sv
hdl/sdv_root_cell.sv
hdl/sphere_signed_distance_voxel_core.sv
dv/tb_sphere_signed_distance_voxel_core.sv
